// File: rtl/core/hrp_pkg.sv
// Shared types, constants and text tables for the HTTP response header parser.
// Used by the name matcher, the top level, the checker and the testbench.
// Depends on nothing.
`default_nettype none

package hrp_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_SIG_LAST = POS_W'(8);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [9:0] CODE_LOW  = 10'd100;
    localparam logic [9:0] CODE_HIGH = 10'd600;
    localparam logic [9:0] CODE_SAT  = 10'd999;

    localparam logic [4:0]  LINE_OFF_MAX = 5'd31;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [15:0] CHUNK_LEN    = 16'd7;

    localparam int NAME_NUM    = 6;
    localparam int NAME_MAX    = 32;
    localparam int NAME_CL_UP  = 0;
    localparam int NAME_CL_LO  = 1;
    localparam int NAME_TE_UP  = 2;
    localparam int NAME_TE_LO  = 3;
    localparam int NAME_LOC_UP = 4;
    localparam int NAME_LOC_LO = 5;

    typedef logic [0:NAME_MAX-1][7:0] t_name_text;

    localparam logic [0:15][7:0] SIG_TEXT   = {"HTTP/1.1 ", 56'h0};
    localparam logic [0:7][7:0]  CHUNK_TEXT = {"chunked", 8'h0};

    localparam t_name_text [0:NAME_NUM-1] NAME_TEXT = '{
        {"Content-Length: ", 128'h0},
        {"content-length: ", 128'h0},
        {"Transfer-Encoding: ", 104'h0},
        {"transfer-encoding: ", 104'h0},
        {"Location: ", 176'h0},
        {"location: ", 176'h0}
    };

    localparam logic [0:NAME_NUM-1][4:0] NAME_LEN = '{
        5'd16, 5'd16, 5'd19, 5'd19, 5'd10, 5'd10
    };

    typedef enum logic [2:0] {
        PH_SIG,
        PH_FIRST,
        PH_CODE,
        PH_REST,
        PH_HDR,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        RES_GOOD,
        RES_BAD_SIG,
        RES_BAD_CODE,
        RES_TRUNCATED
    } t_result;

    typedef enum logic [1:0] {
        CODING_NONE,
        CODING_CHUNKED,
        CODING_OTHER
    } t_coding;

    typedef struct packed {
        logic [NAME_NUM-1:0] flags;
        logic                hit;
    } t_name_match;

endpackage

`default_nettype wire

// File: rtl/core/hrp_if.sv
// Valid/ready channel interfaces for the header parser: message bytes in, results out.
// Depends on nothing; field widths are fixed by the block's word formats.
`default_nettype none

interface hrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic [9:0]  status_code;
    logic [2:0]  status_class;
    logic [31:0] content_length;
    logic [1:0]  transfer_coding;
    logic [15:0] location_offset;
    logic [15:0] location_length;
    logic        body_present;
    logic [15:0] body_offset;

    modport source (
        output valid, output result_code, output status_code, output status_class,
        output content_length, output transfer_coding, output location_offset,
        output location_length, output body_present, output body_offset,
        input ready
    );
    modport sink (
        input valid, input result_code, input status_code, input status_class,
        input content_length, input transfer_coding, input location_offset,
        input location_length, input body_present, input body_offset,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/hrp_name_match.sv
// Header name matcher: compares one byte against every name still flagged, at the line offset.
// Depends on hrp_pkg for the name tables and the match result struct.
`default_nettype none

module hrp_name_match (
    input  logic [7:0]                   i_byte,
    input  logic [4:0]                   i_line_off,
    input  logic [hrp_pkg::NAME_NUM-1:0] i_flags,
    output hrp_pkg::t_name_match         o_match
);

    always_comb begin
        o_match.flags = i_flags;
        o_match.hit   = 1'b0;
        for (int i = 0; i < hrp_pkg::NAME_NUM; i++) begin
            if (i_flags[i] && (i_line_off < hrp_pkg::NAME_LEN[i])) begin
                if (i_byte != hrp_pkg::NAME_TEXT[i][i_line_off]) begin
                    o_match.flags[i] = 1'b0;
                end else if (i_line_off == hrp_pkg::NAME_LEN[i] - 5'd1) begin
                    o_match.hit = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/http_response_header_parser_unit.sv
// Top level of the HTTP/1.1 response header parser.
// Depends on hrp_pkg, hrp_if (hrp_byte_if, hrp_result_if) and hrp_name_match.
`default_nettype none

// The parser takes one message byte per clock and never stalls on its own; it stops only
// while a result waits in the output register and the sink is not ready. A byte is held
// in an input register; when it advances, the parse state is updated and, where the byte
// ends the headers or shows an error, the result word is loaded into the output register.
// At most one result is given per message; later bytes are dropped until the byte marked
// last.
module http_response_header_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrp_byte_if.sink      i_byte,
    hrp_result_if.source  o_result
);

    typedef struct packed {
        logic [hrp_pkg::POS_W-1:0]    pos;
        logic                         prev_cr;
        logic                         line_empty;
        logic [hrp_pkg::NAME_NUM-1:0] flags;
        logic                         in_value;
        logic [15:0]                  value_start;
        logic [15:0]                  value_count;
        logic                         chunk_ok;
        logic                         digits_run;
        logic [31:0]                  acc;
        logic [9:0]                   status;
        logic [31:0]                  clen;
        hrp_pkg::t_coding             coding;
        logic [15:0]                  loc_off;
        logic [15:0]                  loc_len;
        logic                         done;
        logic [4:0]                   line_off;
    } t_pstate;

    typedef struct packed {
        hrp_pkg::t_result result_code;
        logic [9:0]       status_code;
        logic [2:0]       status_class;
        logic [31:0]      content_length;
        hrp_pkg::t_coding transfer_coding;
        logic [15:0]      location_offset;
        logic [15:0]      location_length;
        logic             body_present;
        logic [15:0]      body_offset;
    } t_result_word;

    localparam t_pstate PSTATE_RESET = '{
        pos:         '0,
        prev_cr:     1'b0,
        line_empty:  1'b1,
        flags:       '1,
        in_value:    1'b0,
        value_start: '0,
        value_count: '0,
        chunk_ok:    1'b1,
        digits_run:  1'b1,
        acc:         '0,
        status:      '0,
        clen:        '0,
        coding:      hrp_pkg::CODING_NONE,
        loc_off:     '0,
        loc_len:     '0,
        done:        1'b0,
        line_off:    '0
    };

    function automatic t_pstate clear_line(input t_pstate s);
        t_pstate t;
        t            = s;
        t.prev_cr    = 1'b0;
        t.line_empty = 1'b1;
        t.flags      = '1;
        t.in_value   = 1'b0;
        t.line_off   = '0;
        return t;
    endfunction

    function automatic logic code_bad(input logic [9:0] c);
        return (c < hrp_pkg::CODE_LOW) || (c >= hrp_pkg::CODE_HIGH);
    endfunction

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    t_result_word         r_out;
    t_pstate              r_st;
    t_pstate              n_st;
    hrp_pkg::t_phase      r_phase;
    hrp_pkg::t_phase      n_phase;

    logic                 w_in_ready;
    logic                 w_adv;
    logic                 w_digit;
    logic [3:0]           w_dval;
    logic                 w_is_cr;
    logic                 w_crlf;
    logic                 w_overlong;
    logic                 w_sig_bad;
    logic [13:0]          w_code_sum;
    logic [9:0]           w_code_next;
    logic [35:0]          w_len_sum;
    logic [31:0]          w_len_next;
    logic [15:0]          w_val_len;
    logic [15:0]          w_pos_next;
    logic                 w_emit;
    hrp_pkg::t_result     w_res;
    logic [9:0]           w_emit_status;
    t_result_word         w_out;
    hrp_pkg::t_name_match w_match;

    hrp_name_match u_name_match (
        .i_byte     (r_in_byte),
        .i_line_off (r_st.line_off),
        .i_flags    (r_st.flags),
        .o_match    (w_match)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_adv;

    always_comb begin
        w_digit     = r_in_byte inside {[hrp_pkg::CHAR_ZERO:hrp_pkg::CHAR_NINE]};
        w_dval      = r_in_byte[3:0];
        w_is_cr     = (r_in_byte == hrp_pkg::CHAR_CR);
        w_crlf      = r_st.prev_cr && (r_in_byte == hrp_pkg::CHAR_LF);
        w_overlong  = (r_st.pos >= hrp_pkg::POS_LIMIT);
        w_sig_bad   = (r_st.pos > hrp_pkg::POS_SIG_LAST)
                   || (r_in_byte != hrp_pkg::SIG_TEXT[r_st.pos[3:0]]);
        w_code_sum  = {1'b0, r_st.acc[9:0], 3'b000} + {3'b000, r_st.acc[9:0], 1'b0}
                    + {10'd0, w_dval};
        w_code_next = (w_code_sum > {4'd0, hrp_pkg::CODE_SAT}) ? hrp_pkg::CODE_SAT
                                                               : w_code_sum[9:0];
        w_len_sum   = {1'b0, r_st.acc, 3'b000} + {3'b000, r_st.acc, 1'b0} + {32'd0, w_dval};
        w_len_next  = (|w_len_sum[35:32]) ? 32'hFFFF_FFFF : w_len_sum[31:0];
        w_val_len   = (r_st.value_count == 16'd0) ? 16'd0 : r_st.value_count - 16'd1;
        w_pos_next  = 16'(r_st.pos + 1'b1);
    end

    always_comb begin
        w_emit        = 1'b0;
        w_res         = hrp_pkg::RES_GOOD;
        w_emit_status = r_st.status;
        if (w_adv && !r_st.done) begin
            if (w_overlong) begin
                w_emit = 1'b1;
                w_res  = hrp_pkg::RES_TRUNCATED;
            end else begin
                case (r_phase)
                    hrp_pkg::PH_SIG: begin
                        if (w_sig_bad) begin
                            w_emit = 1'b1;
                            w_res  = hrp_pkg::RES_BAD_SIG;
                        end
                    end
                    hrp_pkg::PH_FIRST: begin
                        if (!w_digit) begin
                            w_emit = 1'b1;
                            w_res  = hrp_pkg::RES_BAD_SIG;
                        end
                    end
                    hrp_pkg::PH_CODE: begin
                        if (!w_digit) begin
                            w_emit_status = r_st.acc[9:0];
                            if (code_bad(r_st.acc[9:0])) begin
                                w_emit = 1'b1;
                                w_res  = hrp_pkg::RES_BAD_CODE;
                            end
                        end
                    end
                    hrp_pkg::PH_HDR: begin
                        if (w_crlf && r_st.line_empty) begin
                            w_emit = 1'b1;
                            w_res  = hrp_pkg::RES_GOOD;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!w_emit && r_in_last) begin
                    w_emit = 1'b1;
                    w_res  = hrp_pkg::RES_TRUNCATED;
                    if (r_phase == hrp_pkg::PH_FIRST) begin
                        w_emit_status = {6'd0, w_dval};
                        if (code_bad({6'd0, w_dval})) begin
                            w_res = hrp_pkg::RES_BAD_CODE;
                        end
                    end else if ((r_phase == hrp_pkg::PH_CODE) && w_digit) begin
                        w_emit_status = w_code_next;
                        if (code_bad(w_code_next)) begin
                            w_res = hrp_pkg::RES_BAD_CODE;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (w_adv) begin
            if (r_in_last) begin
                n_phase = hrp_pkg::PH_SIG;
            end else if (w_emit) begin
                n_phase = hrp_pkg::PH_DONE;
            end else begin
                case (r_phase)
                    hrp_pkg::PH_SIG: begin
                        if (r_st.pos == hrp_pkg::POS_SIG_LAST) begin
                            n_phase = hrp_pkg::PH_FIRST;
                        end
                    end
                    hrp_pkg::PH_FIRST: begin
                        n_phase = hrp_pkg::PH_CODE;
                    end
                    hrp_pkg::PH_CODE: begin
                        if (!w_digit) begin
                            n_phase = hrp_pkg::PH_REST;
                        end
                    end
                    hrp_pkg::PH_REST: begin
                        if (w_crlf) begin
                            n_phase = hrp_pkg::PH_HDR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_st = r_st;
        if (w_adv) begin
            if (!r_st.done && !w_overlong) begin
                case (r_phase)
                    hrp_pkg::PH_FIRST: begin
                        n_st.acc = {28'd0, w_dval};
                    end
                    hrp_pkg::PH_CODE: begin
                        if (w_digit) begin
                            n_st.acc = {22'd0, w_code_next};
                        end else begin
                            n_st.status  = r_st.acc[9:0];
                            n_st.prev_cr = w_is_cr;
                        end
                    end
                    hrp_pkg::PH_REST: begin
                        if (w_crlf) begin
                            n_st = clear_line(r_st);
                        end else begin
                            n_st.prev_cr = w_is_cr;
                        end
                    end
                    hrp_pkg::PH_HDR: begin
                        if (w_crlf) begin
                            if (!r_st.line_empty) begin
                                if (r_st.in_value) begin
                                    if (r_st.flags[hrp_pkg::NAME_CL_UP]
                                            || r_st.flags[hrp_pkg::NAME_CL_LO]) begin
                                        n_st.clen = r_st.acc;
                                    end else if (r_st.flags[hrp_pkg::NAME_TE_UP]
                                            || r_st.flags[hrp_pkg::NAME_TE_LO]) begin
                                        n_st.coding = (r_st.chunk_ok
                                                       && (w_val_len >= hrp_pkg::CHUNK_LEN))
                                                    ? hrp_pkg::CODING_CHUNKED
                                                    : hrp_pkg::CODING_OTHER;
                                    end else if (r_st.flags[hrp_pkg::NAME_LOC_UP]
                                            || r_st.flags[hrp_pkg::NAME_LOC_LO]) begin
                                        n_st.loc_off = r_st.value_start;
                                        n_st.loc_len = w_val_len;
                                    end
                                end
                                n_st = clear_line(n_st);
                            end
                        end else begin
                            n_st.line_empty = r_st.line_empty && w_is_cr && !r_st.prev_cr;
                            if (r_st.in_value) begin
                                if ((r_st.value_count < hrp_pkg::CHUNK_LEN)
                                        && (r_in_byte
                                            != hrp_pkg::CHUNK_TEXT[r_st.value_count[2:0]])) begin
                                    n_st.chunk_ok = 1'b0;
                                end
                                if (r_st.digits_run && w_digit) begin
                                    n_st.acc = w_len_next;
                                end else begin
                                    n_st.digits_run = 1'b0;
                                end
                                if (r_st.value_count != hrp_pkg::COUNT_MAX) begin
                                    n_st.value_count = r_st.value_count + 16'd1;
                                end
                            end else begin
                                n_st.flags = w_match.flags;
                                if (w_match.hit) begin
                                    n_st.in_value    = 1'b1;
                                    n_st.value_start = w_pos_next;
                                    n_st.value_count = '0;
                                    n_st.chunk_ok    = 1'b1;
                                    n_st.digits_run  = 1'b1;
                                    n_st.acc         = '0;
                                end
                            end
                            if (r_st.line_off != hrp_pkg::LINE_OFF_MAX) begin
                                n_st.line_off = r_st.line_off + 5'd1;
                            end
                            n_st.prev_cr = w_is_cr;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_emit) begin
                n_st.done = 1'b1;
            end
            if (r_st.pos < hrp_pkg::POS_LIMIT) begin
                n_st.pos = r_st.pos + 1'b1;
            end
            if (r_in_last) begin
                n_st = PSTATE_RESET;
            end
        end
    end

    always_comb begin
        w_out             = '0;
        w_out.result_code = w_res;
        w_out.status_code = w_emit_status;
        if (w_res == hrp_pkg::RES_GOOD) begin
            if (r_st.status < 10'd200) begin
                w_out.status_class = 3'd0;
            end else if (r_st.status < 10'd300) begin
                w_out.status_class = 3'd1;
            end else if (r_st.status < 10'd400) begin
                w_out.status_class = 3'd2;
            end else if (r_st.status < 10'd500) begin
                w_out.status_class = 3'd3;
            end else begin
                w_out.status_class = 3'd4;
            end
            w_out.content_length  = r_st.clen;
            w_out.transfer_coding = r_st.coding;
            w_out.location_offset = r_st.loc_off;
            w_out.location_length = r_st.loc_len;
            w_out.body_present    = !r_in_last;
            w_out.body_offset     = r_in_last ? 16'd0 : w_pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= PSTATE_RESET;
            r_phase     <= hrp_pkg::PH_SIG;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_st    <= n_st;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
        if (w_adv && w_emit) begin
            r_out <= w_out;
        end
    end

    assign i_byte.ready             = w_in_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.result_code     = r_out.result_code;
    assign o_result.status_code     = r_out.status_code;
    assign o_result.status_class    = r_out.status_class;
    assign o_result.content_length  = r_out.content_length;
    assign o_result.transfer_coding = r_out.transfer_coding;
    assign o_result.location_offset = r_out.location_offset;
    assign o_result.location_length = r_out.location_length;
    assign o_result.body_present    = r_out.body_present;
    assign o_result.body_offset     = r_out.body_offset;

endmodule

`default_nettype wire

// File: rtl/core/hrp_checker.sv
// Port-level checker for the header parser, bound to the top level below.
// Depends on hrp_pkg for the result codes.
`default_nettype none

module hrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_result_code,
    input logic [9:0]  i_status_code,
    input logic [2:0]  i_status_class,
    input logic [31:0] i_content_length,
    input logic [1:0]  i_transfer_coding,
    input logic [15:0] i_location_offset,
    input logic [15:0] i_location_length,
    input logic        i_body_present,
    input logic [15:0] i_body_offset
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result word dropped before it was taken.");

    a_good_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_code == hrp_pkg::RES_GOOD)
        |-> (i_status_code >= 10'd100) && (i_status_code < 10'd600)
            && (i_status_class <= 3'd4))
        else $error("Good result carries a status code out of range.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_code != hrp_pkg::RES_GOOD)
        |-> (i_status_class == 3'd0) && (i_content_length == 32'd0)
            && (i_transfer_coding == 2'd0) && (i_location_offset == 16'd0)
            && (i_location_length == 16'd0) && !i_body_present
            && (i_body_offset == 16'd0))
        else $error("Error result carries header fields.");

    a_no_body_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_body_present |-> (i_body_offset == 16'd0))
        else $error("Body offset given without a body.");

endmodule

bind http_response_header_parser_unit hrp_checker u_hrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_result_code     (o_result.result_code),
    .i_status_code     (o_result.status_code),
    .i_status_class    (o_result.status_class),
    .i_content_length  (o_result.content_length),
    .i_transfer_coding (o_result.transfer_coding),
    .i_location_offset (o_result.location_offset),
    .i_location_length (o_result.location_length),
    .i_body_present    (o_result.body_present),
    .i_body_offset     (o_result.body_offset)
);

`default_nettype wire

// File: tb/tb_http_response_header_parser_unit.sv
// Self-checking testbench for http_response_header_parser_unit: drives message bytes with
// random gaps and stalls and checks every result word against a built-in model or typed row.
// Depends on the top level, hrp_pkg, hrp_byte_if and hrp_result_if from the RTL.
`default_nettype none

module tb_http_response_header_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 1250;
    localparam int MIN_WORDS    = 48;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        t_result     res;
        logic [9:0]  status;
        logic [2:0]  cls;
        logic [31:0] clen;
        t_coding     coding;
        logic [15:0] loc_off;
        logic [15:0] loc_len;
        logic        body;
        logic [15:0] body_off;
    } t_hdr_word;

    typedef struct {
        string   txt;
        bit      last;
        bit      typed;
        t_result res;
        int      code;
        int      cls;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hrp_byte_if   byte_ch ();
    hrp_result_if result_ch ();

    http_response_header_parser_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    string sig_str   = "HTTP/1.1 ";
    string chunk_str = "chunked";
    string hdr_names [6] = '{
        "Content-Length: ", "content-length: ",
        "Transfer-Encoding: ", "transfer-encoding: ",
        "Location: ", "location: "
    };

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{"HTTP/1.1 200 OK\015\n\015\n", 1'b1, 1'b1, RES_GOOD, 200, 1},
        '{"HTTP/1.1 200 OK\015\n\015\nAB", 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{"HTTP/1.0 200 OK\015\n\015\n", 1'b1, 1'b1, RES_BAD_SIG, 0, 0},
        '{"HTTP/1.1 x", 1'b1, 1'b1, RES_BAD_SIG, 0, 0},
        '{"HTTP/1.1 099 X\015\n\015\n", 1'b1, 1'b1, RES_BAD_CODE, 99, 0},
        '{"HTTP/1.1 600 X\015\n\015\n", 1'b1, 1'b1, RES_BAD_CODE, 600, 0},
        '{"HTTP/1.1 12345 X\015\n\015\n", 1'b1, 1'b1, RES_BAD_CODE, 999, 0},
        '{"HTTP/1.1 204", 1'b1, 1'b1, RES_TRUNCATED, 204, 0},
        '{"HTTP/1.1 050", 1'b1, 1'b1, RES_BAD_CODE, 50, 0},
        '{"HTTP/1.1 100 Continue\015\n", 1'b1, 1'b1, RES_TRUNCATED, 100, 0},
        '{"HTTP/1.1 599 E\015\nServer: a\015\n", 1'b1, 1'b1, RES_TRUNCATED, 599, 0},
        '{"H", 1'b1, 1'b1, RES_TRUNCATED, 0, 0},
        '{{"HTTP/1.1 301 Moved\015\nLocation: /a/b\015\n",
           "Content-Length: 42\015\n\015\n"}, 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{{"HTTP/1.1 200 OK\015\ntransfer-encoding: chunked\015\n",
           "content-length: 99999999999\015\n\015\n"}, 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{{"HTTP/1.1 200 OK\015\nTransfer-Encoding: gzip\015\n",
           "Transfer-Encoding: chunk\015\nlocation: x\015\n",
           "Location: yz\015\n\015\nQ"}, 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{{"HTTP/1.1 404 N\015F\nX\015\nContent-Length: 7\0155\015\n",
           "\n\015\015\n\015\n"}, 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{{"HTTP/1.1 500 E\015\nContent-Length:5\015\nLocation:x\015\n",
           " Location: y\015\nContent-Length: 12ab34\015\n\015\n"}, 1'b1, 1'b0,
          RES_GOOD, 0, 0},
        '{{"HTTP/1.1 200 K\015\nContent-Length: 4294967295\015\n",
           "Transfer-Encoding: chunkedness\015\nLocation: \015\n\015\n"}, 1'b1, 1'b0,
          RES_GOOD, 0, 0},
        '{"HTTP/1.1 200\015\n\015\n", 1'b1, 1'b1, RES_GOOD, 200, 1},
        '{"HTTP/1.1 302 F\015\n\015\n", 1'b0, 1'b0, RES_GOOD, 0, 0},
        '{"junk\377", 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{"HTTP/1.1 403 \015\015\n\015\n", 1'b1, 1'b0, RES_GOOD, 0, 0},
        '{"HTTP/1.1 503 S\015\nX: y\015\n\015", 1'b1, 1'b1, RES_TRUNCATED, 503, 0}
    };

    int unsigned pos;
    t_phase      phase;
    bit          prev_cr;
    bit          line_blank;
    bit [5:0]    name_hits;
    bit          in_val;
    logic [15:0] val_start;
    logic [15:0] val_count;
    bit          chunk_ok;
    logic [31:0] acc;
    logic [9:0]  st_code;
    logic [31:0] clen;
    t_coding     coding;
    logic [15:0] loc_off;
    logic [15:0] loc_len;
    bit          done;
    int          line_off;
    bit          digits_on;

    t_hdr_word   due_words [$];
    int          words_due_total;
    int          bad_words;
    logic [7:0]  msg_q [$];
    bit          calm;
    bit          steady;
    bit          hold_req;
    int          idle_pct;
    bit          typed_on;
    t_hdr_word   typed_word;

    function automatic bit is_dec(input logic [7:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    function automatic void open_line();
        prev_cr    = 1'b0;
        line_blank = 1'b1;
        name_hits  = '1;
        in_val     = 1'b0;
        line_off   = 0;
    endfunction

    function automatic void clear_parser();
        pos       = 0;
        phase     = PH_SIG;
        open_line();
        val_start = '0;
        val_count = '0;
        chunk_ok  = 1'b1;
        acc       = '0;
        st_code   = '0;
        clen      = '0;
        coding    = CODING_NONE;
        loc_off   = '0;
        loc_len   = '0;
        done      = 1'b0;
        digits_on = 1'b1;
    endfunction

    function automatic t_hdr_word error_word(input t_result code);
        t_hdr_word r;
        r        = '0;
        r.res    = code;
        r.status = st_code;
        done     = 1'b1;
        phase    = PH_DONE;
        return r;
    endfunction

    function automatic void close_line();
        logic [15:0] len;
        len = (val_count > 16'd0) ? val_count - 16'd1 : 16'd0;
        if (in_val) begin
            for (int i = 0; i < 6; i++) begin
                if (name_hits[i]) begin
                    if (i < 2) begin
                        clen = acc;
                    end else if (i < 4) begin
                        coding = (chunk_ok && len >= 16'd7) ? CODING_CHUNKED : CODING_OTHER;
                    end else begin
                        loc_off = val_start;
                        loc_len = len;
                    end
                    break;
                end
            end
        end
        open_line();
    endfunction

    function automatic void scan_header(input logic [7:0] b);
        longint v;
        line_blank = line_blank && b == CHAR_CR && !prev_cr;
        if (in_val) begin
            if (val_count < 16'd7 && b != chunk_str[val_count])
                chunk_ok = 1'b0;
            if (digits_on && is_dec(b)) begin
                v   = longint'(acc) * 10 + longint'(b - CHAR_ZERO);
                acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
            end else begin
                digits_on = 1'b0;
            end
            if (val_count < 16'hFFFF)
                val_count++;
        end else begin
            for (int i = 0; i < 6; i++) begin
                if (name_hits[i] && line_off < hdr_names[i].len()) begin
                    if (b != hdr_names[i][line_off]) begin
                        name_hits[i] = 1'b0;
                    end else if (line_off + 1 == hdr_names[i].len()) begin
                        in_val    = 1'b1;
                        val_start = 16'(pos + 1);
                        val_count = '0;
                        chunk_ok  = 1'b1;
                        digits_on = 1'b1;
                        acc       = '0;
                    end
                end
            end
        end
        if (line_off < 31)
            line_off++;
        prev_cr = (b == CHAR_CR);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input bit last, output t_hdr_word r);
        bit          hit;
        logic [31:0] v;
        hit = 1'b0;
        r   = '0;
        if (!done) begin
            if (pos >= MAX_MESSAGE_BYTES) begin
                r   = error_word(RES_TRUNCATED);
                hit = 1'b1;
            end else begin
                case (phase)
                    PH_SIG: begin
                        if (pos >= 9 || b != sig_str[pos]) begin
                            r   = error_word(RES_BAD_SIG);
                            hit = 1'b1;
                        end else if (pos == 8) begin
                            phase = PH_FIRST;
                        end
                    end
                    PH_FIRST: begin
                        if (!is_dec(b)) begin
                            r   = error_word(RES_BAD_SIG);
                            hit = 1'b1;
                        end else begin
                            acc   = 32'(b - CHAR_ZERO);
                            phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (is_dec(b)) begin
                            v   = acc * 32'd10 + 32'(b - CHAR_ZERO);
                            acc = (v > 32'd999) ? 32'd999 : v;
                        end else begin
                            st_code = acc[9:0];
                            if (st_code < CODE_LOW || st_code >= CODE_HIGH) begin
                                r   = error_word(RES_BAD_CODE);
                                hit = 1'b1;
                            end else begin
                                phase   = PH_REST;
                                prev_cr = (b == CHAR_CR);
                            end
                        end
                    end
                    PH_REST: begin
                        if (prev_cr && b == CHAR_LF) begin
                            phase = PH_HDR;
                            open_line();
                        end else begin
                            prev_cr = (b == CHAR_CR);
                        end
                    end
                    PH_HDR: begin
                        if (prev_cr && b == CHAR_LF) begin
                            if (line_blank) begin
                                r.res      = RES_GOOD;
                                r.status   = st_code;
                                r.cls      = 3'(st_code / 10'd100 - 10'd1);
                                r.clen     = clen;
                                r.coding   = coding;
                                r.loc_off  = loc_off;
                                r.loc_len  = loc_len;
                                r.body     = !last;
                                r.body_off = last ? 16'd0 : 16'(pos + 1);
                                done       = 1'b1;
                                phase      = PH_DONE;
                                hit        = 1'b1;
                            end else begin
                                close_line();
                            end
                        end else begin
                            scan_header(b);
                        end
                    end
                    default: ;
                endcase
            end
            if (!hit && last) begin
                if (phase == PH_CODE) begin
                    st_code = acc[9:0];
                    if (st_code < CODE_LOW || st_code >= CODE_HIGH)
                        r = error_word(RES_BAD_CODE);
                    else
                        r = error_word(RES_TRUNCATED);
                end else begin
                    r = error_word(RES_TRUNCATED);
                end
                hit = 1'b1;
            end
        end
        if (pos < MAX_MESSAGE_BYTES)
            pos++;
        if (last)
            clear_parser();
        return hit;
    endfunction

    function automatic string word_text(input t_hdr_word r);
        return $sformatf("res=%0d status=%0d class=%0d length=%0d coding=%0d loc=%0d+%0d body=%0d@%0d",
                         r.res, r.status, r.cls, r.clen, r.coding, r.loc_off, r.loc_len,
                         r.body, r.body_off);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) msg_q.push_back(8'(CHAR_ZERO + $urandom_range(9, 0)));
    endtask

    task automatic add_word(input int n);
        repeat (n) msg_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        t_hdr_word r;
        int        gap;
        gap = 0;
        if (!calm && !steady && $urandom_range(99, 0) < idle_pct)
            gap = $urandom_range(14, 1);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (parse_byte(b, last, r)) begin
            due_words.push_back(typed_on ? typed_word : r);
            words_due_total++;
        end
    endtask

    task automatic send_message(input bit end_last);
        idle_pct = $urandom_range(2, 0) * 10;
        foreach (msg_q[i])
            send_byte(msg_q[i], end_last && i == msg_q.size() - 1);
    endtask

    task automatic build_random_message();
        int    kind;
        int    n;
        string nm;
        msg_q.delete();
        kind = $urandom_range(99, 0);
        if (kind < 15) begin
            if ($urandom_range(1, 0) == 1)
                add_text(sig_str.substr(0, $urandom_range(8, 0)));
            n = $urandom_range(12, 1);
            repeat (n) begin
                case ($urandom_range(3, 0))
                    0: msg_q.push_back(8'h00);
                    1: msg_q.push_back(8'hFF);
                    default: msg_q.push_back(8'($urandom_range(255, 0)));
                endcase
            end
            return;
        end
        add_text(sig_str);
        case ($urandom_range(9, 0))
            0: add_digits($urandom_range(2, 1));
            1: add_digits($urandom_range(5, 4));
            2: begin
                msg_q.push_back($urandom_range(1, 0) ? CHAR_ZERO : 8'(CHAR_ZERO + 6));
                add_digits(2);
            end
            default: add_text($sformatf("%0d", $urandom_range(599, 100)));
        endcase
        if ($urandom_range(4, 0) != 0) begin
            add_text(" ");
            add_word($urandom_range(6, 0));
        end
        add_text("\015\n");
        n = $urandom_range(4, 0);
        repeat (n) begin
            case ($urandom_range(5, 0))
                0: begin
                    add_text(hdr_names[$urandom_range(1, 0)]);
                    add_digits($urandom_range(12, 1));
                    if ($urandom_range(3, 0) == 0)
                        add_word(2);
                end
                1: begin
                    add_text(hdr_names[2 + $urandom_range(1, 0)]);
                    case ($urandom_range(3, 0))
                        0: add_text("chunked");
                        1: add_text("chunk");
                        2: add_word($urandom_range(9, 0));
                        default: add_text("chunked, gzip");
                    endcase
                end
                2: begin
                    add_text(hdr_names[4 + $urandom_range(1, 0)]);
                    add_text("/");
                    add_word($urandom_range(20, 0));
                end
                3: begin
                    add_text("Server: ");
                    add_word($urandom_range(8, 1));
                end
                4: begin
                    nm = hdr_names[$urandom_range(5, 0)];
                    nm[$urandom_range(nm.len() - 1, 0)] = 8'($urandom_range(8'h7A, 8'h61));
                    add_text(nm);
                    add_word($urandom_range(4, 0));
                end
                default: begin
                    add_text("X-A: ");
                    add_word(1);
                    msg_q.push_back($urandom_range(1, 0) ? CHAR_CR : CHAR_LF);
                    add_word(2);
                end
            endcase
            add_text("\015\n");
        end
        if ($urandom_range(6, 0) != 0) begin
            add_text("\015\n");
            add_word($urandom_range(4, 0));
        end
        if (kind < 30) begin
            if ($urandom_range(1, 0) == 1)
                msg_q[$urandom_range(msg_q.size() - 1, 0)] = 8'($urandom_range(255, 0));
            else
                msg_q = msg_q[0:$urandom_range(msg_q.size() - 1, 0)];
        end
    endtask

    // The blank line's LF lands on the last 16-bit offset, so the body offset wraps to zero.
    task automatic build_long_location();
        msg_q.delete();
        add_text("HTTP/1.1 200 OK\015\nLocation: ");
        while (msg_q.size() < 65532)
            msg_q.push_back(8'($urandom_range(8'h7A, 8'h61)));
        add_text("\015\n\015\nZ");
    endtask

    task automatic build_overlong();
        msg_q.delete();
        add_text("HTTP/1.1 200 OK\015\nX-Fill: ");
        while (msg_q.size() < 65540)
            msg_q.push_back(8'($urandom_range(8'h7A, 8'h61)));
    endtask

    task automatic check_word();
        t_hdr_word got;
        t_hdr_word want;
        got.res      = t_result'(result_ch.result_code);
        got.status   = result_ch.status_code;
        got.cls      = result_ch.status_class;
        got.clen     = result_ch.content_length;
        got.coding   = t_coding'(result_ch.transfer_coding);
        got.loc_off  = result_ch.location_offset;
        got.loc_len  = result_ch.location_length;
        got.body     = result_ch.body_present;
        got.body_off = result_ch.body_offset;
        if (due_words.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
                $display("unexpected result word: %s", word_text(got));
        end else begin
            want = due_words.pop_front();
            if (got.res !== want.res || got.status !== want.status || got.cls !== want.cls ||
                got.clen !== want.clen || got.coding !== want.coding ||
                got.loc_off !== want.loc_off || got.loc_len !== want.loc_len ||
                got.body !== want.body || got.body_off !== want.body_off) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("result mismatch: expected %s, got %s",
                             word_text(want), word_text(got));
            end
        end
    endtask

    initial begin : sink_side
        int stall;
        stall = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (result_ch.valid && result_ch.ready)
                check_word();
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(7, 0) == 0) begin
                stall = $urandom_range(13, 0);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int msg_no;
        int rand_bytes;
        int base_words;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        bad_words         = 0;
        words_due_total   = 0;
        calm              = 1'b0;
        steady            = 1'b0;
        hold_req          = 1'b0;
        typed_on          = 1'b0;
        idle_pct          = 10;
        clear_parser();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            typed_on          = dir_rows[k].typed;
            typed_word        = '0;
            typed_word.res    = dir_rows[k].res;
            typed_word.status = 10'(dir_rows[k].code);
            typed_word.cls    = 3'(dir_rows[k].cls);
            msg_q.delete();
            add_text(dir_rows[k].txt);
            send_message(dir_rows[k].last);
        end
        typed_on = 1'b0;

        msg_no     = 0;
        rand_bytes = 0;
        base_words = words_due_total;
        while (rand_bytes < RANDOM_BYTES || words_due_total - base_words < MIN_WORDS) begin
            if (msg_no == 0 || msg_no == 20)
                hold_req = 1'b1;
            if (msg_no == 8 || msg_no == 14) begin
                steady = 1'b1;
                if (msg_no == 8)
                    build_long_location();
                else
                    build_overlong();
                send_message(1'b1);
                steady = 1'b0;
            end else begin
                build_random_message();
                send_message($urandom_range(19, 0) != 0);
                rand_bytes += msg_q.size();
            end
            if (rand_bytes >= RANDOM_BYTES * 4 / 5)
                calm = 1'b1;
            msg_no++;
        end
        byte_ch.valid <= 1'b0;

        while (due_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (bad_words == 0 && due_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #(25ms);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
